// ----- rtl/mshw_pkg.sv -----
// Shared types and constants of the multi-slot heartbeat watchdog.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package mshw_pkg;

   localparam int OPCODE_W   = 2;
   localparam int SLOT_W     = 4;
   localparam int TIMEOUT_W  = 24;
   localparam int THROTTLE_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [OPCODE_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_HEARTBEAT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_TICK       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE = 1'd1;

   localparam logic [THROTTLE_W-1:0] THROTTLE_RESET = 16'd5;

   typedef struct packed {
      logic reg_en;
      logic unreg_en;
      logic beat_en;
      logic expire_en;
   } tbl_cmd_type;

   typedef struct packed {
      logic hit;
      logic beat_ok;
   } tbl_status_type;

endpackage

// ----- rtl/mshw_chan_if.sv -----
// Request and result channel interfaces of the heartbeat watchdog.
// Depends on mshw_pkg for the payload widths.
`timescale 1ns / 1ps

interface mshw_req_if;
   logic                            valid;
   logic                            ready;
   logic [mshw_pkg::OPCODE_W-1:0]   opcode;
   logic [mshw_pkg::SLOT_W-1:0]     slot;
   logic [mshw_pkg::TIMEOUT_W-1:0]  timeout_ticks;

   modport source (output valid, output opcode, output slot, output timeout_ticks,
                   input ready);
   modport sink (input valid, input opcode, input slot, input timeout_ticks,
                 output ready);
endinterface

interface mshw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mshw_pkg::SLOT_W-1:0] expired_slot;
   logic                        last;

   modport source (output valid, output expired_slot, output last, input ready);
   modport sink (input valid, input expired_slot, input last, output ready);
endinterface

// ----- rtl/multi_slot_heartbeat_watchdog.sv -----
// Top level of the multi-slot heartbeat watchdog: sequencer, time counter,
// configuration registers and result register. Depends on mshw_pkg,
// mshw_chan_if and mshw_slot_table.
//
//   Channel   Direction  Handshake          Payload
//   req_chan  in         valid / ready      opcode, slot, timeout_ticks
//   rsp_chan  out        valid / ready      expired_slot, last
//   csr_*     in         csr_write_en only  csr_index, csr_wdata
//
// Register, unregister and heartbeat are handled in the idle state and leave it idle.
// A tick with scanning disabled only advances the time counter; with scanning
// enabled it also walks every slot, one slot compare per cycle on the shared
// comparator unless a hit waits on rsp_chan.ready, then flushes the held expiry.
// Reset is synchronous; the slot store needs no clearing pass.
// Each expiry is held back until the next one is found, so that last can be marked.
`timescale 1ns / 1ps

module multi_slot_heartbeat_watchdog #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mshw_req_if.sink                             req_chan,
   mshw_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [mshw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mshw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int EXT_W = (IDX_W > mshw_pkg::SLOT_W) ? IDX_W : mshw_pkg::SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]                          state_ff,    state_in;
   logic [TIME_BITS-1:0]                time_now_ff, time_now_in;
   logic                                enable_ff,   enable_in;
   logic [mshw_pkg::THROTTLE_W-1:0]     throttle_ff, throttle_in;
   logic [IDX_W-1:0]                    scan_idx_ff, scan_idx_in;
   logic                                pend_ff,     pend_in;
   logic [IDX_W-1:0]                    pend_idx_ff, pend_idx_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mshw_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                req_ready;
   logic                                accept;
   logic                                out_free;
   logic                                slot_ok;
   logic [EXT_W-1:0]                    slot_ext;
   logic [IDX_W-1:0]                    req_idx;
   mshw_pkg::tbl_cmd_type               cmd;
   mshw_pkg::tbl_status_type            status;

   mshw_slot_table #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_slot_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_idx    (req_idx),
      .scan_idx   (scan_idx_ff),
      .timeout_in (req_chan.timeout_ticks),
      .time_now   (time_now_ff),
      .throttle   (throttle_ff),
      .status     (status)
   );

   assign req_ready             = (state_ff == ST_IDLE) && !reset;
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.expired_slot = rsp_slot_ff;
   assign rsp_chan.last         = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      time_now_in  = time_now_ff;
      enable_in    = enable_ff;
      throttle_in  = throttle_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;

      slot_ext = EXT_W'(req_chan.slot);
      req_idx  = slot_ext[IDX_W-1:0];
      slot_ok  = int'(req_chan.slot) < NUM_SLOTS;
      accept   = req_chan.valid && req_ready;
      out_free = !rsp_valid_ff || rsp_chan.ready;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         case (csr_index)
            mshw_pkg::CSR_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            mshw_pkg::CSR_THROTTLE: begin
               throttle_in = csr_wdata[mshw_pkg::THROTTLE_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.opcode)
                  mshw_pkg::OP_TICK: begin
                     time_now_in = time_now_ff + TIME_BITS'(1);
                     if (enable_ff) begin
                        state_in    = ST_SCAN;
                        scan_idx_in = '0;
                     end
                  end
                  mshw_pkg::OP_REGISTER: begin
                     cmd.reg_en = slot_ok;
                  end
                  mshw_pkg::OP_UNREGISTER: begin
                     cmd.unreg_en = slot_ok;
                  end
                  mshw_pkg::OP_HEARTBEAT: begin
                     cmd.beat_en = slot_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!(status.hit && pend_ff && !out_free)) begin
               if (status.hit) begin
                  cmd.expire_en = 1'b1;
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = mshw_pkg::SLOT_W'(pend_idx_ff);
                     rsp_last_in  = 1'b0;
                  end
                  pend_in     = 1'b1;
                  pend_idx_in = scan_idx_ff;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = mshw_pkg::SLOT_W'(pend_idx_ff);
               rsp_last_in  = 1'b1;
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_now_ff  <= '0;
         enable_ff    <= 1'b0;
         throttle_ff  <= mshw_pkg::THROTTLE_RESET;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_now_ff  <= time_now_in;
         enable_ff    <= enable_in;
         throttle_ff  <= throttle_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- rtl/mshw_slot_table.sv -----
// Per-slot watchdog storage with the shared expiry and throttle comparators.
// Depends on mshw_pkg for the command and status structs.
`timescale 1ns / 1ps

module mshw_slot_table #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 32,
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mshw_pkg::tbl_cmd_type               cmd,
   input  logic [IDX_W-1:0]                    req_idx,
   input  logic [IDX_W-1:0]                    scan_idx,
   input  logic [mshw_pkg::TIMEOUT_W-1:0]      timeout_in,
   input  logic [TIME_BITS-1:0]                time_now,
   input  logic [mshw_pkg::THROTTLE_W-1:0]     throttle,
   output mshw_pkg::tbl_status_type            status
);

   localparam int CMP_W = (TIME_BITS > mshw_pkg::TIMEOUT_W) ? TIME_BITS : mshw_pkg::TIMEOUT_W;

   logic                           valid_ff     [NUM_SLOTS];
   logic [TIME_BITS-1:0]           last_beat_ff [NUM_SLOTS];
   logic [TIME_BITS-1:0]           last_acc_ff  [NUM_SLOTS];
   logic                           acc_once_ff  [NUM_SLOTS];
   logic [mshw_pkg::TIMEOUT_W-1:0] timeout_ff   [NUM_SLOTS];

   logic [TIME_BITS-1:0] scan_elapsed;
   logic [TIME_BITS-1:0] beat_elapsed;

   always_comb begin
      scan_elapsed   = time_now - last_beat_ff[scan_idx];
      beat_elapsed   = time_now - last_acc_ff[req_idx];
      status.hit     = valid_ff[scan_idx] &&
                       (CMP_W'(scan_elapsed) > CMP_W'(timeout_ff[scan_idx]));
      status.beat_ok = valid_ff[req_idx] &&
                       (!acc_once_ff[req_idx] || (beat_elapsed >= TIME_BITS'(throttle)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.reg_en) begin
         valid_ff[req_idx] <= 1'b1;
      end else if (cmd.unreg_en) begin
         valid_ff[req_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reg_en) begin
         timeout_ff[req_idx]   <= timeout_in;
         last_beat_ff[req_idx] <= time_now;
         acc_once_ff[req_idx]  <= 1'b0;
      end else if (cmd.beat_en && status.beat_ok) begin
         last_beat_ff[req_idx] <= time_now;
         last_acc_ff[req_idx]  <= time_now;
         acc_once_ff[req_idx]  <= 1'b1;
      end else if (cmd.expire_en) begin
         last_beat_ff[scan_idx] <= time_now;
      end
   end

endmodule

// ----- rtl/mshw_checker.sv -----
// Port-level checks of the heartbeat watchdog and the bind that attaches them.
// Depends on mshw_pkg and on the top level multi_slot_heartbeat_watchdog.
`timescale 1ns / 1ps

module mshw_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [mshw_pkg::OPCODE_W-1:0]     req_opcode,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_last
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A result was withdrawn before its transfer.");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Reset did not clear the result channel.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode != mshw_pkg::OP_TICK) |=> req_ready || reset)
      else $error("A non-tick request held the block busy.");

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(rsp_valid && !rsp_last))
      else $error("The block went idle with a tick's final result still pending.");

endmodule

bind multi_slot_heartbeat_watchdog mshw_checker u_mshw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_opcode (req_chan.opcode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_last   (rsp_chan.last)
);

// ----- test/multi_slot_heartbeat_watchdog_tb.sv -----
// Self-checking testbench of the multi-slot heartbeat watchdog: a directed table, then random
// phases under several register settings, with every expiry checked against a slot-table model or a typed row.
// Depends on mshw_pkg, mshw_chan_if and multi_slot_heartbeat_watchdog.
`timescale 1ns / 1ps

module multi_slot_heartbeat_watchdog_tb;

   localparam int OPCODE_W      = mshw_pkg::OPCODE_W;
   localparam int SLOT_W        = mshw_pkg::SLOT_W;
   localparam int TIMEOUT_W     = mshw_pkg::TIMEOUT_W;
   localparam int THROTTLE_W    = mshw_pkg::THROTTLE_W;
   localparam int CSR_IDX_W     = mshw_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W    = mshw_pkg::CSR_DATA_W;
   localparam int N_SLOTS       = 16;
   localparam int SETTLE_CYCLES = 30;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 32;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              last;
   } expiry_type;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [OPCODE_W-1:0]    op;
      logic [SLOT_W-1:0]      slot;
      logic [TIMEOUT_W-1:0]   arg;
      bit                     typed;
      logic [4:0]             n_results;
      logic [SLOT_W-1:0]      x_slot;
      logic                   x_last;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mshw_req_if req_if ();
   mshw_rsp_if rsp_if ();

   multi_slot_heartbeat_watchdog #(
      .NUM_SLOTS(N_SLOTS),
      .TIME_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic [31:0]           wd_now;
   bit                    wd_valid [N_SLOTS];
   logic [31:0]           wd_beat [N_SLOTS];
   logic [31:0]           wd_accepted [N_SLOTS];
   bit                    wd_once [N_SLOTS];
   logic [TIMEOUT_W-1:0]  wd_timeout [N_SLOTS];
   bit                    wd_enable;
   logic [THROTTLE_W-1:0] wd_throttle;

   expiry_type   scan_hits [$];
   expiry_type   pending_expiries [$];
   stim_row_type dir_rows [24];
   int           mismatches = 0;
   int           cycle_count = 0;
   bit           calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : run_limit
      while (cycle_count <= CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   function automatic void reset_watchdog_model();
      wd_now      = '0;
      wd_enable   = 1'b0;
      wd_throttle = mshw_pkg::THROTTLE_RESET;
      for (int i = 0; i < N_SLOTS; i++) wd_valid[i] = 1'b0;
   endfunction

   // Applies one accepted request to the slot table and collects the expiries it causes.
   function automatic void advance_watchdog(logic [OPCODE_W-1:0] op, logic [SLOT_W-1:0] sl,
                                            logic [TIMEOUT_W-1:0] tm);
      expiry_type hit;
      scan_hits.delete();
      case (op)
         mshw_pkg::OP_TICK: begin
            wd_now = wd_now + 32'd1;
            if (wd_enable) begin
               for (int i = 0; i < N_SLOTS; i++) begin
                  if (wd_valid[i] && (wd_now - wd_beat[i]) > {8'd0, wd_timeout[i]}) begin
                     wd_beat[i] = wd_now;
                     hit.slot = SLOT_W'(i);
                     hit.last = 1'b0;
                     scan_hits.insert(scan_hits.size(), hit);
                  end
               end
               if (scan_hits.size() > 0) scan_hits[scan_hits.size() - 1].last = 1'b1;
            end
         end
         mshw_pkg::OP_REGISTER: begin
            wd_valid[sl]    = 1'b1;
            wd_timeout[sl]  = tm;
            wd_beat[sl]     = wd_now;
            wd_accepted[sl] = '0;
            wd_once[sl]     = 1'b0;
         end
         mshw_pkg::OP_UNREGISTER: wd_valid[sl] = 1'b0;
         default: begin
            if (wd_valid[sl] &&
                !(wd_once[sl] && (wd_now - wd_accepted[sl]) < {16'd0, wd_throttle})) begin
               wd_accepted[sl] = wd_now;
               wd_beat[sl]     = wd_now;
               wd_once[sl]     = 1'b1;
            end
         end
      endcase
   endfunction

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] sl,
                            input logic [TIMEOUT_W-1:0] tm, input bit use_model);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.opcode        <= op;
      req_if.slot          <= sl;
      req_if.timeout_ticks <= tm;
      do @(posedge clock); while (!req_if.ready);
      advance_watchdog(op, sl, tm);
      if (use_model) begin
         foreach (scan_hits[i]) pending_expiries.insert(pending_expiries.size(), scan_hits[i]);
      end
   endtask

   task automatic settle();
      while (pending_expiries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == mshw_pkg::CSR_ENABLE) wd_enable = val[0];
      else wd_throttle = val;
   endtask

   initial begin : result_monitor
      int         stall;
      expiry_type want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_expiries.size() == 0) begin
               $error("unexpected result: expired_slot %0d, last %0b",
                      rsp_if.expired_slot, rsp_if.last);
               mismatches++;
            end else begin
               want = pending_expiries.pop_front();
               if (rsp_if.expired_slot !== want.slot) begin
                  $error("expired_slot: expected %0d, got %0d", want.slot, rsp_if.expired_slot);
                  mismatches++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_if.last);
                  mismatches++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      stim_row_type          row;
      expiry_type            typed_hit;
      logic [OPCODE_W-1:0]   op;
      logic [SLOT_W-1:0]     sl;
      logic [TIMEOUT_W-1:0]  tm;
      logic [THROTTLE_W-1:0] thr;
      bit                    en;
      int                    pick;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.opcode        <= mshw_pkg::OP_TICK;
      req_if.slot          <= '0;
      req_if.timeout_ticks <= '0;
      rsp_if.ready         <= 1'b0;
      csr_write_en         <= 1'b0;
      csr_index            <= mshw_pkg::CSR_ENABLE;
      csr_wdata            <= '0;
      reset_watchdog_model();

      // Expected counts are typed in only where they follow directly from the row.
      dir_rows = '{
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b1, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_REGISTER,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_REGISTER,
           4'd15, 24'hFFFFFF,  1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b1, 5'd0, 4'd0, 1'b0},
         '{ROW_CSR,  mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd1,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b1, 5'd1, 4'd0, 1'b1},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd0,  24'h5A5A5A,  1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd3,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_REGISTER,
           4'd7,  24'd1,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_UNREGISTER,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_UNREGISTER,
           4'd0,  24'hFFFFFF,  1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_CSR,  mshw_pkg::CSR_THROTTLE, mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd7,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd7,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_CSR,  mshw_pkg::CSR_THROTTLE, mshw_pkg::OP_TICK,
           4'd0,  24'h00FFFF,  1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd15, 24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_HEARTBEAT,
           4'd15, 24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_REGISTER,
           4'd15, 24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_TICK,
           4'd0,  24'd0,       1'b0, 5'd0, 4'd0, 1'b0},
         '{ROW_ITEM, mshw_pkg::CSR_ENABLE,   mshw_pkg::OP_UNREGISTER,
           4'd5,  24'hA5A5A5,  1'b0, 5'd0, 4'd0, 1'b0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         if (row.kind == ROW_CSR) begin
            req_if.valid <= 1'b0;
            settle();
            write_csr(row.reg_idx, row.arg[CSR_DATA_W-1:0]);
         end else begin
            send_item(row.op, row.slot, row.arg, !row.typed);
            if (row.typed && row.n_results == 5'd1) begin
               typed_hit.slot = row.x_slot;
               typed_hit.last = row.x_last;
               pending_expiries.insert(pending_expiries.size(), typed_hit);
            end
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         req_if.valid <= 1'b0;
         settle();
         calm = (ph == 5);
         case (ph)
            0: thr = '0;
            1: thr = '1;
            2: thr = 16'd3;
            3: thr = THROTTLE_W'($urandom);
            4: thr = THROTTLE_W'($urandom_range(0, 6));
            default: thr = 16'd1;
         endcase
         en = (ph != 3);
         // Both registers in back-to-back cycles, with the write enable held high between them.
         csr_write_en <= 1'b1;
         csr_index    <= mshw_pkg::CSR_ENABLE;
         csr_wdata    <= {15'($urandom), en};
         @(posedge clock);
         wd_enable = en;
         csr_index <= mshw_pkg::CSR_THROTTLE;
         csr_wdata <= thr;
         @(posedge clock);
         wd_throttle = thr;
         csr_write_en <= 1'b0;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 4 && k == PHASE_ITEMS / 2) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (pending_expiries.size() != 0) @(posedge clock);
            end
            sl   = SLOT_W'($urandom);
            tm   = TIMEOUT_W'($urandom);
            pick = $urandom_range(0, 99);
            if (ph == 2 && k < N_SLOTS) begin
               // Every slot with a zero timeout, so that the next tick reports all of them.
               op = mshw_pkg::OP_REGISTER;
               sl = SLOT_W'(k);
               tm = '0;
            end else if (ph == 2 && k == N_SLOTS) begin
               op = mshw_pkg::OP_TICK;
            end else if (pick < 36) begin
               op = mshw_pkg::OP_TICK;
            end else if (pick < 60) begin
               op = mshw_pkg::OP_HEARTBEAT;
            end else if (pick < 84) begin
               op   = mshw_pkg::OP_REGISTER;
               pick = $urandom_range(0, 9);
               if (pick < 7) tm = TIMEOUT_W'($urandom_range(0, 12));
               else if (pick == 7) tm = '1;
               else if (pick == 8) tm = '0;
            end else begin
               op = mshw_pkg::OP_UNREGISTER;
            end
            send_item(op, sl, tm, 1'b1);
         end
      end

      req_if.valid <= 1'b0;
      settle();
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mshw_pkg.sv
rtl/mshw_chan_if.sv
rtl/mshw_slot_table.sv
rtl/multi_slot_heartbeat_watchdog.sv
rtl/mshw_checker.sv
test/multi_slot_heartbeat_watchdog_tb.sv
